### hdl/amept_pkg.sv
package amept_pkg;

   // Field widths.
   localparam int RAW_W   = 16;
   localparam int VAL_W   = 12;
   localparam int DIFF_W  = VAL_W + 1;
   localparam int SQ_W    = 2 * VAL_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int MAG_W   = 18;
   localparam int ID_W    = 8;
   localparam int WARM_W  = 4;
   localparam int MASK_W  = 3;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   // Raw samples are left-justified; the low bits below the 12-bit value drop off.
   localparam int VAL_SHIFT = RAW_W - VAL_W;

   localparam int MAG_SHIFT_DEF = 8;

   localparam logic [ID_W-1:0]   EXPECTED_ID_RST  = 8'h33;
   localparam logic [WARM_W-1:0] WARMUP_COUNT_RST = 4'd2;

   // Register indexes (byte address divided by four).
   localparam logic REG_EXPECTED_ID  = 1'b0;
   localparam logic REG_WARMUP_COUNT = 1'b1;

   // Operation codes.
   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // Clear mask bit positions.
   localparam int CLR_ALARM   = 0;
   localparam int CLR_MONITOR = 1;
   localparam int CLR_KEEP    = 2;

   typedef enum logic [1:0] {
      FAULT_NONE = 2'd0,
      FAULT_BUS  = 2'd1,
      FAULT_ID   = 2'd2
   } fault_type;

   typedef struct packed {
      logic [ID_W-1:0]   expected_id;
      logic [WARM_W-1:0] warmup_count;
   } cfg_type;

   typedef struct packed {
      logic                    operation;
      logic [ID_W-1:0]         device_id;
      logic                    bus_error;
      logic signed [RAW_W-1:0] x_raw;
      logic signed [RAW_W-1:0] y_raw;
      logic signed [RAW_W-1:0] z_raw;
      logic [MASK_W-1:0]       clear_mask;
   } req_item_type;

   typedef struct packed {
      logic [MAG_W-1:0]        magnitude;
      logic [MAG_W-1:0]        alarm_peak;
      logic [MAG_W-1:0]        monitor_peak;
      logic [MAG_W-1:0]        keep_peak;
      logic signed [VAL_W-1:0] x_value;
      logic signed [VAL_W-1:0] y_value;
      logic signed [VAL_W-1:0] z_value;
      logic                    valid_res;
      fault_type               fault;
      logic                    sensor_up;
   } rsp_item_type;

endpackage

### hdl/accel_motion_energy_peak_tracker_top.sv
// Motion-energy peak tracker for a three-axis accelerometer.
//
// The request channel (req_valid / req_stall) carries one beat per sensor
// reading or restart. Each beat produces exactly one beat on the response
// channel (rsp_valid / rsp_stall) with the converted 12-bit axis values, the
// squared-difference magnitude, three peak holds, the fault code and the
// sensor-up flag. A beat is taken on a clock edge where valid is high and
// stall is low.
//
// A beat enters the input register when accepted; its response is
// registered when the compute stage advances. Throughput is one beat per
// cycle while the receiver does not stall, set by the single compute stage
// between those two registers (three 12x12 squares, a three-way add and the
// peak compares). When the receiver stalls, the response register holds;
// the input register can still take one beat, then req_stall rises.
//
// A synchronous reset clears the history, peak holds, warm-up count and the
// sensor-up flag, and loads expected_id with 0x33 and warmup_count with 2.
// The user must write the APB port (expected_id at byte 0, warmup_count at
// byte 4) only while no beat is in flight; the block does not enforce this.
module accel_motion_energy_peak_tracker_top #(
   parameter int MAG_SHIFT = amept_pkg::MAG_SHIFT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [amept_pkg::ID_W-1:0]          req_device_id,
   input  logic                                req_bus_error,
   input  logic signed [amept_pkg::RAW_W-1:0]  req_x_raw,
   input  logic signed [amept_pkg::RAW_W-1:0]  req_y_raw,
   input  logic signed [amept_pkg::RAW_W-1:0]  req_z_raw,
   input  logic [amept_pkg::MASK_W-1:0]        req_clear_mask,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [amept_pkg::MAG_W-1:0]         rsp_magnitude,
   output logic [amept_pkg::MAG_W-1:0]         rsp_alarm_peak,
   output logic [amept_pkg::MAG_W-1:0]         rsp_monitor_peak,
   output logic [amept_pkg::MAG_W-1:0]         rsp_keep_peak,
   output logic signed [amept_pkg::VAL_W-1:0]  rsp_x_value,
   output logic signed [amept_pkg::VAL_W-1:0]  rsp_y_value,
   output logic signed [amept_pkg::VAL_W-1:0]  rsp_z_value,
   output logic                                rsp_valid_res,
   output logic [1:0]                          rsp_fault,
   output logic                                rsp_sensor_up,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [amept_pkg::ADDR_W-1:0]        paddr,
   input  logic [amept_pkg::DATA_W-1:0]        pwdata,
   output logic [amept_pkg::DATA_W-1:0]        prdata,
   output logic                                pready
);

   amept_pkg::cfg_type      cfg;
   amept_pkg::req_item_type req_item;
   amept_pkg::req_item_type in_item_ff;
   amept_pkg::rsp_item_type result;
   amept_pkg::rsp_item_type out_item_ff;

   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_ready;
   logic advance;
   logic accept;

   amept_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   always_comb begin
      req_item.operation  = req_operation;
      req_item.device_id  = req_device_id;
      req_item.bus_error  = req_bus_error;
      req_item.x_raw      = req_x_raw;
      req_item.y_raw      = req_y_raw;
      req_item.z_raw      = req_z_raw;
      req_item.clear_mask = req_clear_mask;
   end

   // The response register is free when empty or being drained this cycle.
   // The compute stage moves forward whenever that is so and the input register
   // holds a beat, and the input register can refill in the same cycle.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   amept_core #(
      .MAG_SHIFT (MAG_SHIFT)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_magnitude    = out_item_ff.magnitude;
   assign rsp_alarm_peak   = out_item_ff.alarm_peak;
   assign rsp_monitor_peak = out_item_ff.monitor_peak;
   assign rsp_keep_peak    = out_item_ff.keep_peak;
   assign rsp_x_value      = out_item_ff.x_value;
   assign rsp_y_value      = out_item_ff.y_value;
   assign rsp_z_value      = out_item_ff.z_value;
   assign rsp_valid_res    = out_item_ff.valid_res;
   assign rsp_fault        = out_item_ff.fault;
   assign rsp_sensor_up    = out_item_ff.sensor_up;

endmodule

### hdl/amept_axis.sv
module amept_axis (
   input  logic signed [amept_pkg::RAW_W-1:0] raw,
   input  logic signed [amept_pkg::VAL_W-1:0] last,
   output logic signed [amept_pkg::VAL_W-1:0] value,
   output logic [amept_pkg::SQ_W-1:0]         square
);

   logic                               neg;
   logic [amept_pkg::RAW_W-1:0]        raw_abs;
   logic [amept_pkg::VAL_W-1:0]        val_abs;
   logic signed [amept_pkg::DIFF_W-1:0] diff;
   logic [amept_pkg::VAL_W-1:0]        diff_abs;

   // Sign-magnitude truncation toward zero; the most negative sample maps to -2048.
   assign neg      = raw[amept_pkg::RAW_W-1];
   assign raw_abs  = neg ? (~raw + 1'b1) : raw;
   assign val_abs  = raw_abs[amept_pkg::RAW_W-1:amept_pkg::VAL_SHIFT];
   assign value    = neg ? (~val_abs + 1'b1) : val_abs;

   assign diff     = {value[amept_pkg::VAL_W-1], value} - {last[amept_pkg::VAL_W-1], last};
   assign diff_abs = diff[amept_pkg::DIFF_W-1] ? amept_pkg::VAL_W'(-diff)
                                               : amept_pkg::VAL_W'(diff);
   assign square   = diff_abs * diff_abs;

endmodule

### hdl/amept_csr.sv
module amept_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [amept_pkg::ADDR_W-1:0]  paddr,
   input  logic [amept_pkg::DATA_W-1:0]  pwdata,
   output logic [amept_pkg::DATA_W-1:0]  prdata,
   output logic                          pready,
   output amept_pkg::cfg_type            cfg
);

   amept_pkg::cfg_type cfg_ff;
   amept_pkg::cfg_type cfg_in;
   logic               reg_index;
   logic               wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[amept_pkg::ADDR_W-1];
   assign wr_en     = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            amept_pkg::REG_EXPECTED_ID:
               cfg_in.expected_id = pwdata[amept_pkg::ID_W-1:0];
            amept_pkg::REG_WARMUP_COUNT:
               cfg_in.warmup_count = pwdata[amept_pkg::WARM_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         amept_pkg::REG_EXPECTED_ID:
            prdata = amept_pkg::DATA_W'(cfg_ff.expected_id);
         amept_pkg::REG_WARMUP_COUNT:
            prdata = amept_pkg::DATA_W'(cfg_ff.warmup_count);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_id  <= amept_pkg::EXPECTED_ID_RST;
         cfg_ff.warmup_count <= amept_pkg::WARMUP_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/amept_core.sv
module amept_core #(
   parameter int MAG_SHIFT = amept_pkg::MAG_SHIFT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  amept_pkg::req_item_type item,
   input  amept_pkg::cfg_type      cfg,
   output amept_pkg::rsp_item_type result
);

   logic signed [amept_pkg::VAL_W-1:0] last_x_ff, last_x_in;
   logic signed [amept_pkg::VAL_W-1:0] last_y_ff, last_y_in;
   logic signed [amept_pkg::VAL_W-1:0] last_z_ff, last_z_in;
   logic [amept_pkg::WARM_W-1:0]       warmup_left_ff, warmup_left_in;
   logic [amept_pkg::MAG_W-1:0]        alarm_hold_ff, alarm_hold_in;
   logic [amept_pkg::MAG_W-1:0]        monitor_hold_ff, monitor_hold_in;
   logic [amept_pkg::MAG_W-1:0]        keep_hold_ff, keep_hold_in;
   logic                               up_ff, up_in;

   logic signed [amept_pkg::VAL_W-1:0] vx, vy, vz;
   logic [amept_pkg::SQ_W-1:0]         sq_x, sq_y, sq_z;
   logic [amept_pkg::SUM_W-1:0]        sum;
   logic [amept_pkg::SUM_W-1:0]        sum_shifted;
   logic [amept_pkg::MAG_W-1:0]        mag_calc;
   logic [amept_pkg::MAG_W-1:0]        alarm_base, monitor_base, keep_base;
   amept_pkg::fault_type               fault;
   logic                               good_sample;
   logic                               valid;

   amept_axis u_axis_x (.raw(item.x_raw), .last(last_x_ff), .value(vx), .square(sq_x));
   amept_axis u_axis_y (.raw(item.y_raw), .last(last_y_ff), .value(vy), .square(sq_y));
   amept_axis u_axis_z (.raw(item.z_raw), .last(last_z_ff), .value(vz), .square(sq_z));

   assign sum = amept_pkg::SUM_W'(sq_x) + amept_pkg::SUM_W'(sq_y)
              + amept_pkg::SUM_W'(sq_z);
   assign sum_shifted = sum >> MAG_SHIFT;
   assign mag_calc = (|sum_shifted[amept_pkg::SUM_W-1:amept_pkg::MAG_W]) ? '1
                   : sum_shifted[amept_pkg::MAG_W-1:0];

   always_comb begin
      priority if (item.bus_error) begin
         fault = amept_pkg::FAULT_BUS;
      end else if (item.device_id != cfg.expected_id) begin
         fault = amept_pkg::FAULT_ID;
      end else begin
         fault = amept_pkg::FAULT_NONE;
      end
   end

   assign good_sample = (fault == amept_pkg::FAULT_NONE) &&
                        (item.operation == amept_pkg::OP_SAMPLE);
   assign valid       = good_sample && (warmup_left_ff == '0);

   // Clears take effect before this beat's peak update.
   assign alarm_base   = item.clear_mask[amept_pkg::CLR_ALARM]   ? '0 : alarm_hold_ff;
   assign monitor_base = item.clear_mask[amept_pkg::CLR_MONITOR] ? '0 : monitor_hold_ff;
   assign keep_base    = item.clear_mask[amept_pkg::CLR_KEEP]    ? '0 : keep_hold_ff;

   always_comb begin
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      last_z_in      = last_z_ff;
      warmup_left_in = warmup_left_ff;
      up_in          = up_ff;
      alarm_hold_in   = alarm_base;
      monitor_hold_in = monitor_base;
      keep_hold_in    = keep_base;

      if (fault != amept_pkg::FAULT_NONE) begin
         up_in = 1'b0;
      end else if (item.operation == amept_pkg::OP_RESTART) begin
         up_in          = 1'b1;
         warmup_left_in = cfg.warmup_count;
      end else begin
         last_x_in = vx;
         last_y_in = vy;
         last_z_in = vz;
         if (warmup_left_ff != '0) begin
            warmup_left_in = warmup_left_ff - 1'b1;
         end
      end

      if (valid) begin
         if (mag_calc > alarm_base) begin
            alarm_hold_in = mag_calc;
         end
         if (mag_calc > monitor_base) begin
            monitor_hold_in = mag_calc;
         end
         if (mag_calc > keep_base) begin
            keep_hold_in = mag_calc;
         end
      end
   end

   always_comb begin
      result.magnitude    = valid ? mag_calc : '0;
      result.alarm_peak   = alarm_hold_in;
      result.monitor_peak = monitor_hold_in;
      result.keep_peak    = keep_hold_in;
      result.x_value      = good_sample ? vx : '0;
      result.y_value      = good_sample ? vy : '0;
      result.z_value      = good_sample ? vz : '0;
      result.valid_res    = valid;
      result.fault        = fault;
      result.sensor_up    = up_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff       <= '0;
         last_y_ff       <= '0;
         last_z_ff       <= '0;
         warmup_left_ff  <= '0;
         alarm_hold_ff   <= '0;
         monitor_hold_ff <= '0;
         keep_hold_ff    <= '0;
         up_ff           <= 1'b0;
      end else if (advance) begin
         last_x_ff       <= last_x_in;
         last_y_ff       <= last_y_in;
         last_z_ff       <= last_z_in;
         warmup_left_ff  <= warmup_left_in;
         alarm_hold_ff   <= alarm_hold_in;
         monitor_hold_ff <= monitor_hold_in;
         keep_hold_ff    <= keep_hold_in;
         up_ff           <= up_in;
      end
   end

endmodule

### test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import amept_pkg::*;

   localparam int MAG_SHIFT          = MAG_SHIFT_DEF;
   localparam int MAG_LIMIT          = (1 << MAG_W) - 1;
   localparam int MAX_IDLE           = 11;
   localparam int RANDOM_PHASE_BEATS = 200;
   localparam int MODE_SPAN          = 50;
   localparam int SETTLE_CYCLES      = 8;

   logic                     clock;
   logic                     reset;

   logic                     req_valid;
   logic                     req_stall;
   logic                     req_operation;
   logic [ID_W-1:0]          req_device_id;
   logic                     req_bus_error;
   logic signed [RAW_W-1:0]  req_x_raw;
   logic signed [RAW_W-1:0]  req_y_raw;
   logic signed [RAW_W-1:0]  req_z_raw;
   logic [MASK_W-1:0]        req_clear_mask;

   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [MAG_W-1:0]         rsp_magnitude;
   logic [MAG_W-1:0]         rsp_alarm_peak;
   logic [MAG_W-1:0]         rsp_monitor_peak;
   logic [MAG_W-1:0]         rsp_keep_peak;
   logic signed [VAL_W-1:0]  rsp_x_value;
   logic signed [VAL_W-1:0]  rsp_y_value;
   logic signed [VAL_W-1:0]  rsp_z_value;
   logic                     rsp_valid_res;
   logic [1:0]               rsp_fault;
   logic                     rsp_sensor_up;

   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [ADDR_W-1:0]        paddr;
   logic [DATA_W-1:0]        pwdata;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   accel_motion_energy_peak_tracker_top #(
      .MAG_SHIFT(MAG_SHIFT)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_device_id    (req_device_id),
      .req_bus_error    (req_bus_error),
      .req_x_raw        (req_x_raw),
      .req_y_raw        (req_y_raw),
      .req_z_raw        (req_z_raw),
      .req_clear_mask   (req_clear_mask),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_magnitude    (rsp_magnitude),
      .rsp_alarm_peak   (rsp_alarm_peak),
      .rsp_monitor_peak (rsp_monitor_peak),
      .rsp_keep_peak    (rsp_keep_peak),
      .rsp_x_value      (rsp_x_value),
      .rsp_y_value      (rsp_y_value),
      .rsp_z_value      (rsp_z_value),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_fault        (rsp_fault),
      .rsp_sensor_up    (rsp_sensor_up),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // Our own copy of the tracker: the two settings, the previous converted
   // reading per axis, the remaining priming count, the three peak holds and
   // the sensor-up flag. It advances once per accepted request beat.
   logic [ID_W-1:0]          id_setting;
   logic [WARM_W-1:0]        warmup_setting;
   logic signed [VAL_W-1:0]  prev_x;
   logic signed [VAL_W-1:0]  prev_y;
   logic signed [VAL_W-1:0]  prev_z;
   logic [WARM_W-1:0]        priming_left;
   logic [MAG_W-1:0]         alarm_max;
   logic [MAG_W-1:0]         monitor_max;
   logic [MAG_W-1:0]         keep_max;
   logic                     sensor_ok;

   // Reports still owed by the block, oldest first. Every request beat owes
   // exactly one response beat.
   rsp_item_type             pending_reports[$];
   int                       mismatch_count;

   // Idle modes of the two sides; the random test flips them in stretches so
   // that runs with no gaps at all alternate with heavily gapped ones.
   bit                       sender_idles;
   bit                       receiver_stalls;

   // Random-walk position per axis, so that most readings move a little
   // from the last one and the peak holds see a spread of magnitudes.
   logic signed [RAW_W-1:0]  walk [3];

   // 2 ns clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #1_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Left-justified 16-bit sample to 12 bits, truncating the magnitude toward
   // zero. The most negative raw value lands on -2048 rather than wrapping.
   function automatic logic signed [VAL_W-1:0] truncate_sample(logic signed [RAW_W-1:0] raw);
      int full;
      int mag;
      full = raw;
      mag  = (full < 0) ? -full : full;
      mag  = mag >> VAL_SHIFT;
      return (full < 0) ? VAL_W'(-mag) : VAL_W'(mag);
   endfunction

   function automatic int axis_energy(logic signed [VAL_W-1:0] now,
                                      logic signed [VAL_W-1:0] was);
      int delta;
      delta = int'(now) - int'(was);
      return delta * delta;
   endfunction

   // One step of the tracker. The clear mask acts first on every beat, then
   // a bus error outranks an identity mismatch, and any fault takes the
   // sensor down without touching history or the priming count.
   function automatic rsp_item_type track_reading(req_item_type item);
      rsp_item_type rep;
      int           total;
      int           mag;
      rep = '0;
      if (item.clear_mask[CLR_ALARM])   alarm_max   = '0;
      if (item.clear_mask[CLR_MONITOR]) monitor_max = '0;
      if (item.clear_mask[CLR_KEEP])    keep_max    = '0;

      if (item.bus_error)
         rep.fault = FAULT_BUS;
      else if (item.device_id != id_setting)
         rep.fault = FAULT_ID;
      else
         rep.fault = FAULT_NONE;

      if (rep.fault != FAULT_NONE) begin
         sensor_ok = 1'b0;
      end else if (item.operation == OP_RESTART) begin
         sensor_ok    = 1'b1;
         priming_left = warmup_setting;
      end else begin
         // A good reading is taken even while the sensor is marked down.
         rep.x_value = truncate_sample(item.x_raw);
         rep.y_value = truncate_sample(item.y_raw);
         rep.z_value = truncate_sample(item.z_raw);
         total = axis_energy(rep.x_value, prev_x) + axis_energy(rep.y_value, prev_y)
               + axis_energy(rep.z_value, prev_z);
         prev_x = rep.x_value;
         prev_y = rep.y_value;
         prev_z = rep.z_value;
         if (priming_left != '0) begin
            priming_left = priming_left - 1'b1;
         end else begin
            mag = total >> MAG_SHIFT;
            rep.magnitude = (mag > MAG_LIMIT) ? MAG_W'(MAG_LIMIT) : MAG_W'(mag);
            if (rep.magnitude > alarm_max)   alarm_max   = rep.magnitude;
            if (rep.magnitude > monitor_max) monitor_max = rep.magnitude;
            if (rep.magnitude > keep_max)    keep_max    = rep.magnitude;
            rep.valid_res = 1'b1;
         end
      end

      rep.alarm_peak   = alarm_max;
      rep.monitor_peak = monitor_max;
      rep.keep_peak    = keep_max;
      rep.sensor_up    = sensor_ok;
      return rep;
   endfunction

   task automatic check_field(string what, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // Response side. Before each beat it may hold stall high for a drawn
   // number of cycles, then it takes the next beat and compares every field
   // against the oldest owed report. Outputs are read at the clock edge, so
   // they are the values the block presented during the accepting cycle.
   initial begin : response_checker
      int           hold;
      rsp_item_type want;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         hold = receiver_stalls ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: response beat, expected none, actual magnitude %0d",
                     $time, rsp_magnitude);
         end else begin
            want = pending_reports.pop_front();
            check_field("magnitude",    want.magnitude,    rsp_magnitude);
            check_field("alarm_peak",   want.alarm_peak,   rsp_alarm_peak);
            check_field("monitor_peak", want.monitor_peak, rsp_monitor_peak);
            check_field("keep_peak",    want.keep_peak,    rsp_keep_peak);
            check_field("x_value",      want.x_value,      rsp_x_value);
            check_field("y_value",      want.y_value,      rsp_y_value);
            check_field("z_value",      want.z_value,      rsp_z_value);
            check_field("valid_res",    want.valid_res,    rsp_valid_res);
            check_field("fault",        want.fault,        rsp_fault);
            check_field("sensor_up",    want.sensor_up,    rsp_sensor_up);
         end
      end
   end

   // Request side. An optional gap with valid low, then the beat is presented
   // and held until the block takes it. Valid stays high afterwards so that
   // a following beat with no gap goes out back to back.
   task automatic send_reading(req_item_type item);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= item.operation;
      req_device_id  <= item.device_id;
      req_bus_error  <= item.bus_error;
      req_x_raw      <= item.x_raw;
      req_y_raw      <= item.y_raw;
      req_z_raw      <= item.z_raw;
      req_clear_mask <= item.clear_mask;
      do @(posedge clock); while (req_stall);
      pending_reports.push_back(track_reading(item));
   endtask

   // Drop valid and let every owed report come back. Since each beat yields
   // a report, an empty queue means the block is idle.
   task automatic stop_requests();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // One APB transfer: setup, then access until pready. psel is left high so
   // that a following transfer can start in the same cycle; the caller
   // releases the bus once the sequence is over.
   task automatic bus_access(input logic is_write, input logic index,
                             input logic [DATA_W-1:0] wdata,
                             output logic [DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= ADDR_W'({index, 2'b00});
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   // Read both registers back and compare them with the settings we track.
   task automatic verify_settings();
      logic [DATA_W-1:0] readback;
      bus_access(1'b0, REG_EXPECTED_ID, '0, readback);
      check_field("expected_id readback", id_setting, readback);
      bus_access(1'b0, REG_WARMUP_COUNT, '0, readback);
      check_field("warmup_count readback", warmup_setting, readback);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic load_settings(logic [ID_W-1:0] id, logic [WARM_W-1:0] warm);
      logic [DATA_W-1:0] unused;
      bus_access(1'b1, REG_EXPECTED_ID, DATA_W'(id), unused);
      bus_access(1'b1, REG_WARMUP_COUNT, DATA_W'(warm), unused);
      id_setting     = id;
      warmup_setting = warm;
      verify_settings();
   endtask

   function automatic req_item_type make_reading(logic op, logic [ID_W-1:0] id, logic berr,
                                                 logic signed [RAW_W-1:0] x,
                                                 logic signed [RAW_W-1:0] y,
                                                 logic signed [RAW_W-1:0] z,
                                                 logic [MASK_W-1:0] mask);
      req_item_type item;
      item.operation  = op;
      item.device_id  = id;
      item.bus_error  = berr;
      item.x_raw      = x;
      item.y_raw      = y;
      item.z_raw      = z;
      item.clear_mask = mask;
      return item;
   endfunction

   // Mostly small steps around the previous value, with full-range jumps and
   // the extreme codes mixed in.
   function automatic logic signed [RAW_W-1:0] random_axis(int axis);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         walk[axis] = RAW_W'($urandom);
      end else if (pick < 45) begin
         case ($urandom_range(0, 3))
            0: walk[axis] = 16'sh8000;
            1: walk[axis] = 16'sh7FFF;
            2: walk[axis] = '0;
            default: walk[axis] = -16'sd1;
         endcase
      end else begin
         walk[axis] = walk[axis] + RAW_W'($urandom_range(0, 1200)) - 16'sd600;
      end
      return walk[axis];
   endfunction

   // A well-formed stream is good samples with the odd restart; faults and
   // wrong identities are the noise on top.
   function automatic req_item_type random_reading();
      req_item_type item;
      item.operation  = ($urandom_range(0, 99) < 4) ? OP_RESTART : OP_SAMPLE;
      item.device_id  = ($urandom_range(0, 99) < 92) ? id_setting : ID_W'($urandom);
      item.bus_error  = ($urandom_range(0, 99) < 4);
      item.x_raw      = random_axis(0);
      item.y_raw      = random_axis(1);
      item.z_raw      = random_axis(2);
      item.clear_mask = ($urandom_range(0, 99) < 15) ? MASK_W'($urandom) : '0;
      return item;
   endfunction

   // After reset the registers must hold their documented defaults.
   task automatic test_register_reset();
      verify_settings();
   endtask

   // Default settings: identity 0x33, two priming readings. The sensor starts
   // down, but with no priming pending a good reading is measured at once.
   // After a restart, two readings only prime history, then a full-scale
   // swing on all three axes gives the largest possible magnitude.
   task automatic test_warmup_and_extremes();
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, '0, '0, '0, '0));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sh8000, 16'sh7FFF,
                                -16'sd1, '0));
      send_reading(make_reading(OP_RESTART, id_setting, 1'b0, 16'sh1234, 16'sh7FFF,
                                16'sh8000, '0));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sh7FFF, 16'sh7FFF,
                                16'sh7FFF, '0));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sh8000, 16'sh8000,
                                16'sh8000, '0));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sh7FFF, 16'sh7FFF,
                                16'sh7FFF, '0));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sh8001, 16'sh7FF0,
                                -16'sd17, '0));
      // Values just inside and outside one step of the truncation.
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, -16'sd16, 16'sd15,
                                16'sd16, '0));
   endtask

   // A bus error wins over a wrong identity; any fault drops the sensor and
   // blanks the reading; a wrong identity on a restart does not bring it up.
   task automatic test_fault_handling();
      send_reading(make_reading(OP_RESTART, 8'h00, 1'b1, 16'sh0100, 16'sh0200,
                                16'sh0300, '0));
      send_reading(make_reading(OP_SAMPLE, 8'hFF, 1'b0, 16'sh4000, 16'sh4000,
                                16'sh4000, '0));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b1, 16'sh4000, -16'sh4000,
                                16'sh0000, '0));
      send_reading(make_reading(OP_RESTART, 8'h00, 1'b0, '0, '0, '0, '0));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sd1600, -16'sd1600,
                                16'sd5000, '0));
      send_reading(make_reading(OP_RESTART, id_setting, 1'b0, '0, '0, '0, '0));
   endtask

   // Each clear bit on its own, on a priming, a faulted and a restart beat,
   // then all three together while priming, then two of them at once.
   task automatic test_clear_mask();
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sh6000, -16'sh6000,
                                16'sh2000, MASK_W'(1 << CLR_ALARM)));
      send_reading(make_reading(OP_SAMPLE, 8'h5A, 1'b0, '0, '0, '0,
                                MASK_W'(1 << CLR_MONITOR)));
      send_reading(make_reading(OP_RESTART, id_setting, 1'b0, '0, '0, '0,
                                MASK_W'(1 << CLR_KEEP)));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sh0800, 16'sh0800,
                                16'sh0800, '1));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sh0900, 16'sh0700,
                                16'sh0800, '0));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sh0A00, 16'sh0600,
                                16'sh0800, '0));
      send_reading(make_reading(OP_SAMPLE, id_setting, 1'b0, 16'sh0B00, 16'sh0500,
                                16'sh0800,
                                MASK_W'((1 << CLR_ALARM) | (1 << CLR_KEEP))));
   endtask

   // Random streams under several register settings, the extremes first.
   // The block is drained before every register change. Each phase opens
   // with a good restart so that the stream starts from a known footing.
   task automatic test_random_traffic();
      logic [ID_W-1:0]   id_list   [6];
      logic [WARM_W-1:0] warm_list [6];
      id_list   = '{8'h00, 8'hFF, EXPECTED_ID_RST, 8'h00, 8'h00, 8'h00};
      warm_list = '{4'd0, 4'd15, WARMUP_COUNT_RST, 4'd0, 4'd0, 4'd0};
      for (int p = 3; p < 6; p++) begin
         id_list[p]   = ID_W'($urandom);
         warm_list[p] = WARM_W'($urandom);
      end
      for (int p = 0; p < 6; p++) begin
         stop_requests();
         load_settings(id_list[p], warm_list[p]);
         send_reading(make_reading(OP_RESTART, id_setting, 1'b0, '0, '0, '0, '0));
         for (int n = 0; n < RANDOM_PHASE_BEATS; n++) begin
            if (n % MODE_SPAN == 0) begin
               sender_idles    = $urandom_range(0, 1);
               receiver_stalls = $urandom_range(0, 1);
            end
            send_reading(random_reading());
         end
      end
   endtask

   initial begin : stimulus
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_SAMPLE;
      req_device_id  = '0;
      req_bus_error  = 1'b0;
      req_x_raw      = '0;
      req_y_raw      = '0;
      req_z_raw      = '0;
      req_clear_mask = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;

      id_setting      = EXPECTED_ID_RST;
      warmup_setting  = WARMUP_COUNT_RST;
      prev_x          = '0;
      prev_y          = '0;
      prev_z          = '0;
      priming_left    = '0;
      alarm_max       = '0;
      monitor_max     = '0;
      keep_max        = '0;
      sensor_ok       = 1'b0;
      mismatch_count  = 0;
      walk            = '{default: '0};
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_register_reset();
      test_warmup_and_extremes();
      test_fault_handling();
      test_clear_mask();
      test_random_traffic();

      // Everything sent: wait for the last reports, then keep watching for
      // any stray beat the block might still produce.
      stop_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
